// ----- hw/rtl/sbs_pkg.sv -----
// Shared types, character codes and classification functions for the
// sentence boundary splitter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sbs_pkg;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_FINAL = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic CFG_LEN_LIMIT   = 1'b0;
  localparam logic CFG_COUNT_LIMIT = 1'b1;

  localparam logic [15:0] LEN_LIMIT_RST   = 16'd512;
  localparam logic [15:0] COUNT_LIMIT_RST = 16'd256;

  localparam logic KIND_SENTENCE = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_QUES = 8'h3f;
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_UPA  = 8'h41;
  localparam logic [7:0] CH_UPZ  = 8'h5a;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] sentence_number;
    logic [15:0] start_pos;
    logic [15:0] sentence_length;
    logic [15:0] total_sentences;
    logic        final_status;
    logic        last_result;
  } out_item_t;

  // One queued job: a byte window, how many of its bytes are real, how many
  // of them get handled, and whether end of text follows.
  typedef struct packed {
    logic [2:0][7:0] win;
    logic [1:0]      nvalid;
    logic [1:0]      nhandle;
    logic            fin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [15:0] len_limit;
    logic [15:0] count_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_HANDLE,
    PH_CLOSE,
    PH_SUMMARY
  } phase_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UPA) && (c <= CH_UPZ);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUES);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sbs_front.sv -----
// Front end: accepts input transactions, keeps the two-byte lookahead and
// turns transactions into jobs for the queue. Depends on sbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbs_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  sbs_pkg::in_item_t     in_data,
  output logic                  in_stall,
  input  sbs_pkg::q_status_t    q_stat,
  output logic                  q_push,
  output sbs_pkg::job_t         q_job
);
  import sbs_pkg::*;

  logic [7:0] lb0_r, lb0_nxt;
  logic [7:0] lb1_r, lb1_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    lb0_nxt = lb0_r;
    lb1_nxt = lb1_r;
    fill_nxt = fill_r;
    q_push = 1'b0;
    q_job = '0;
    if (accept) begin
      case (in_data.opcode)
        OP_BYTE: begin
          if (fill_r == 2'd2) begin
            q_push = 1'b1;
            q_job.win = {in_data.text_byte, lb1_r, lb0_r};
            q_job.nvalid = 2'd3;
            q_job.nhandle = 2'd1;
            lb0_nxt = lb1_r;
            lb1_nxt = in_data.text_byte;
          end else begin
            if (fill_r == 2'd0) lb0_nxt = in_data.text_byte;
            else lb1_nxt = in_data.text_byte;
            fill_nxt = fill_r + 2'd1;
          end
        end
        OP_FINAL: begin
          q_push = 1'b1;
          case (fill_r)
            2'd2:    q_job.win = {in_data.text_byte, lb1_r, lb0_r};
            2'd1:    q_job.win = {8'd0, in_data.text_byte, lb0_r};
            default: q_job.win = {8'd0, 8'd0, in_data.text_byte};
          endcase
          q_job.nvalid = fill_r + 2'd1;
          q_job.nhandle = fill_r + 2'd1;
          q_job.fin = 1'b1;
          lb0_nxt = '0;
          lb1_nxt = '0;
          fill_nxt = '0;
        end
        OP_END: begin
          q_push = 1'b1;
          q_job.win = {8'd0, lb1_r, lb0_r};
          q_job.nvalid = fill_r;
          q_job.nhandle = fill_r;
          q_job.fin = 1'b1;
          lb0_nxt = '0;
          lb1_nxt = '0;
          fill_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lb0_r <= '0;
      lb1_r <= '0;
      fill_r <= '0;
    end else begin
      lb0_r <= lb0_nxt;
      lb1_r <= lb1_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sbs_queue.sv -----
// Short job queue between front and back end.
// Depends on sbs_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none
module sbs_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  sbs_pkg::job_t      push_job,
  input  wire logic          pop,
  output sbs_pkg::job_t      head_job,
  output sbs_pkg::q_status_t stat
);
  import sbs_pkg::*;

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_r, wptr_nxt;
  logic [QPTR_BITS-1:0] rptr_r, rptr_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign head_job = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sbs_back.sv -----
// Back end: runs queued jobs one step per cycle unless stalled (byte
// handling, final close, summary), holds the result register. Uses sbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbs_back #(
  parameter int POS_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  sbs_pkg::cfg_t      cfg,
  input  sbs_pkg::job_t      job,
  input  sbs_pkg::q_status_t q_stat,
  output logic               q_pop,
  output logic               out_valid,
  output sbs_pkg::out_item_t out_data,
  input  wire logic          out_stall
);
  import sbs_pkg::*;

  localparam int CW = (POS_BITS > 16) ? POS_BITS : 16;

  phase_t              phase_r, phase_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] seg_r, seg_nxt;
  logic [POS_BITS-1:0] first_r, first_nxt;
  logic [POS_BITS-1:0] last_r, last_nxt;
  logic                ht_r, ht_nxt;
  logic                skip_r, skip_nxt;
  logic [15:0]         cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  always_comb begin
    logic                slot_free, fire, do_handle, emit;
    logic [7:0]          cur, nx, nn;
    logic                has_next, has_nn, term;
    logic [POS_BITS-1:0] after, fp, lp, close_end, raw;
    logic                ht, close_go;
    logic [POS_BITS:0]   len_full;
    out_item_t           res;

    phase_nxt = phase_r;
    k_nxt = k_r;
    pos_nxt = pos_r;
    seg_nxt = seg_r;
    skip_nxt = skip_r;
    cnt_nxt = cnt_r;
    q_pop = 1'b0;
    emit = 1'b0;
    res = '0;
    close_go = 1'b0;
    close_end = '0;
    fp = first_r;
    lp = last_r;
    ht = ht_r;

    slot_free = !out_valid_r || !out_stall;
    fire = !q_stat.empty && slot_free;
    do_handle = (phase_r == PH_HANDLE) && (k_r < job.nhandle);
    after = (pos_r == '1) ? pos_r : pos_r + 1'b1;

    case (k_r)
      2'd0: begin
        cur = job.win[0];
        nx = job.win[1];
        nn = job.win[2];
      end
      2'd1: begin
        cur = job.win[1];
        nx = job.win[2];
        nn = '0;
      end
      default: begin
        cur = job.win[2];
        nx = '0;
        nn = '0;
      end
    endcase
    has_next = ({1'b0, k_r} + 3'd1) < {1'b0, job.nvalid};
    has_nn = ({1'b0, k_r} + 3'd2) < {1'b0, job.nvalid};
    term = is_term(cur) && (!has_next || is_ws(nx)) && (!has_nn || is_upper(nn));

    if (fire) begin
      if (do_handle) begin
        if (skip_r && is_ws(cur)) begin
          seg_nxt = after;
        end else begin
          skip_nxt = 1'b0;
          if (cur == CH_NL) begin
            close_go = 1'b1;
            close_end = pos_r;
            seg_nxt = after;
          end else begin
            if (!is_ws(cur)) begin
              if (!ht) fp = pos_r;
              lp = pos_r;
              ht = 1'b1;
            end
            if (term) begin
              close_go = 1'b1;
              close_end = after;
              seg_nxt = after;
              skip_nxt = 1'b1;
            end
          end
        end
        pos_nxt = after;
        if ((k_r + 2'd1) == job.nhandle) begin
          k_nxt = '0;
          if (job.fin) phase_nxt = PH_CLOSE;
          else q_pop = 1'b1;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end else if (phase_r == PH_SUMMARY) begin
        emit = 1'b1;
        res.result_kind = KIND_SUMMARY;
        res.total_sentences = cnt_r;
        res.final_status = (cnt_r == '0);
        res.last_result = 1'b1;
        q_pop = 1'b1;
        phase_nxt = PH_HANDLE;
        k_nxt = '0;
        pos_nxt = '0;
        seg_nxt = '0;
        skip_nxt = 1'b0;
        cnt_nxt = '0;
        fp = '0;
        lp = '0;
        ht = 1'b0;
      end else begin
        if (seg_r < pos_r) begin
          close_go = 1'b1;
          close_end = pos_r;
        end
        phase_nxt = PH_SUMMARY;
      end
    end

    raw = close_end - seg_r;
    len_full = {1'b0, lp} - {1'b0, fp} + 1'b1;
    if (close_go) begin
      if ((close_end > seg_r) && (CW'(raw) < CW'(cfg.len_limit)) &&
          (cnt_r < cfg.count_limit) && ht) begin
        emit = 1'b1;
        res.result_kind = KIND_SENTENCE;
        res.sentence_number = cnt_r;
        res.start_pos = 16'(fp);
        res.sentence_length = 16'(len_full);
        res.last_result = !job.fin;
        cnt_nxt = cnt_r + 16'd1;
      end
      ht = 1'b0;
    end

    first_nxt = fp;
    last_nxt = lp;
    ht_nxt = ht;

    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (slot_free) begin
      out_valid_nxt = emit;
      if (emit) out_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HANDLE;
      k_r <= '0;
      pos_r <= '0;
      seg_r <= '0;
      first_r <= '0;
      last_r <= '0;
      ht_r <= 1'b0;
      skip_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      k_r <= k_nxt;
      pos_r <= pos_nxt;
      seg_r <= seg_nxt;
      first_r <= first_nxt;
      last_r <= last_nxt;
      ht_r <= ht_nxt;
      skip_r <= skip_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sentence_boundary_splitter.sv -----
// Top level of the sentence boundary splitter: configuration registers,
// front end, job queue and back end. Depends on sbs_pkg, sbs_front,
// sbs_queue and sbs_back.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   sbs_pkg::in_item_t
//  out_     output     out_valid / out_stall sbs_pkg::out_item_t
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// Plain bytes stream at one per cycle until the job queue fills behind a
// stalled result or a final job. A final-byte or end-of-text transaction
// handles each pending byte, then the final close and the summary.
// The four-entry job queue lets the front keep accepting meanwhile.
// Reset is synchronous; it clears all text state and loads the limits
// with 512 and 256. A stalled result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none
module sentence_boundary_splitter #(
  parameter int POS_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  sbs_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  output sbs_pkg::out_item_t out_data,
  input  wire logic          out_stall,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_wdata
);
  import sbs_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  q_status_t q_stat;
  job_t      push_job, head_job;
  logic      q_push, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LEN_LIMIT:   cfg_nxt.len_limit = cfg_wdata;
        CFG_COUNT_LIMIT: cfg_nxt.count_limit = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.len_limit <= LEN_LIMIT_RST;
      cfg_r.count_limit <= COUNT_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  sbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  sbs_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job       (head_job),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_job.fin) |=> (out_valid && out_data.result_kind == KIND_SUMMARY))
    else $error("end-of-text job retired without summary");

endmodule
`default_nettype wire

// ----- sim/sentence_boundary_splitter_checker.sv -----
// Checker for the sentence boundary splitter: watches the input, result and
// register-write ports, predicts every result and compares it. Uses sbs_pkg.
`timescale 1ns / 1ps
module sentence_boundary_splitter_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sbs_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sbs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 exp_depth,
  output int                 sentences_seen,
  output int                 summaries_seen
);
  import sbs_pkg::*;

  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;

  logic [15:0] len_lim;
  logic [15:0] cnt_lim;

  logic [7:0]  pend [0:1];
  logic [1:0]  pend_cnt;
  logic [15:0] pos;
  logic [15:0] seg_begin;
  logic [15:0] text_first;
  logic [15:0] text_last;
  logic        seg_nonblank;
  logic        skip_ws;
  logic [15:0] n_accepted;

  out_item_t step_out[$];
  out_item_t exp_results[$];

  function automatic logic [15:0] bump(logic [15:0] p);
    return (p == 16'hFFFF) ? p : p + 16'd1;
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return c inside {CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
  endfunction

  function automatic logic upper_char(logic [7:0] c);
    return c inside {[CH_UPA:CH_UPZ]};
  endfunction

  function automatic logic mark_char(logic [7:0] c);
    return c inside {CH_DOT, CH_BANG, CH_QUES};
  endfunction

  task automatic clear_text();
    pend[0]      = '0;
    pend[1]      = '0;
    pend_cnt     = '0;
    pos          = '0;
    seg_begin    = '0;
    text_first   = '0;
    text_last    = '0;
    seg_nonblank = 1'b0;
    skip_ws      = 1'b0;
    n_accepted   = '0;
  endtask

  task automatic end_segment(logic [15:0] stop);
    logic [15:0] raw;
    out_item_t   r;
    raw = (stop > seg_begin) ? stop - seg_begin : 16'd0;
    if (raw != 16'd0 && raw < len_lim && n_accepted < cnt_lim && seg_nonblank) begin
      r                 = '0;
      r.result_kind     = KIND_SENTENCE;
      r.sentence_number = n_accepted;
      r.start_pos       = text_first;
      r.sentence_length = text_last - text_first + 16'd1;
      step_out.push_back(r);
      n_accepted++;
    end
    seg_nonblank = 1'b0;
  endtask

  task automatic scan_char(logic [7:0] c, logic has_next, logic [7:0] next_c,
                           logic has_after, logic [7:0] after_c);
    logic [15:0] nxt;
    nxt = bump(pos);
    if (skip_ws) begin
      if (blank_char(c)) begin
        seg_begin = nxt;
        pos       = nxt;
        return;
      end
      skip_ws = 1'b0;
    end
    if (c == CH_NL) begin
      end_segment(pos);
      seg_begin = nxt;
    end else begin
      if (!blank_char(c)) begin
        if (!seg_nonblank) text_first = pos;
        text_last    = pos;
        seg_nonblank = 1'b1;
      end
      if (mark_char(c) && (!has_next || blank_char(next_c)) &&
          (!has_after || upper_char(after_c))) begin
        end_segment(nxt);
        seg_begin = nxt;
        skip_ws   = 1'b1;
      end
    end
    pos = nxt;
  endtask

  task automatic take_byte(logic [7:0] b);
    if (pend_cnt >= 2'd2) begin
      scan_char(pend[0], 1'b1, pend[1], 1'b1, b);
      pend[0] = pend[1];
      pend[1] = b;
    end else begin
      pend[pend_cnt[0]] = b;
      pend_cnt++;
    end
  endtask

  task automatic wrap_up();
    out_item_t r;
    if (pend_cnt >= 2'd2) begin
      scan_char(pend[0], 1'b1, pend[1], 1'b0, 8'h00);
      pend[0]  = pend[1];
      pend_cnt = 2'd1;
    end
    if (pend_cnt == 2'd1) scan_char(pend[0], 1'b0, 8'h00, 1'b0, 8'h00);
    pend_cnt = '0;
    if (seg_begin < pos) end_segment(pos);
    r                 = '0;
    r.result_kind     = KIND_SUMMARY;
    r.total_sentences = n_accepted;
    r.final_status    = (n_accepted == 16'd0);
    step_out.push_back(r);
    clear_text();
  endtask

  task automatic predict(in_item_t it);
    out_item_t r;
    step_out.delete();
    case (it.opcode)
      OP_BYTE:  take_byte(it.text_byte);
      OP_FINAL: begin
        take_byte(it.text_byte);
        wrap_up();
      end
      OP_END:   wrap_up();
      default:  ;
    endcase
    if (step_out.size() > 0) begin
      r             = step_out.pop_back();
      r.last_result = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) exp_results.push_back(step_out[i]);
  endtask

  function automatic bit field_ok(string name, int want, int got);
    if (want == got) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  task automatic compare_result(out_item_t got);
    out_item_t want;
    bit        good;
    if (exp_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      fail_count++;
      return;
    end
    want = exp_results.pop_front();
    good = 1'b1;
    good &= field_ok("result_kind", want.result_kind, got.result_kind);
    good &= field_ok("sentence_number", want.sentence_number, got.sentence_number);
    good &= field_ok("start_pos", want.start_pos, got.start_pos);
    good &= field_ok("sentence_length", want.sentence_length, got.sentence_length);
    good &= field_ok("total_sentences", want.total_sentences, got.total_sentences);
    good &= field_ok("final_status", want.final_status, got.final_status);
    good &= field_ok("last_result", want.last_result, got.last_result);
    if (!good) fail_count++;
    if (got.result_kind == KIND_SUMMARY) summaries_seen++;
    else sentences_seen++;
  endtask

  initial begin
    fail_count     = 0;
    exp_depth      = 0;
    sentences_seen = 0;
    summaries_seen = 0;
    len_lim        = LEN_LIMIT_RST;
    cnt_lim        = COUNT_LIMIT_RST;
    clear_text();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      len_lim = LEN_LIMIT_RST;
      cnt_lim = COUNT_LIMIT_RST;
      clear_text();
      exp_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LEN_LIMIT) len_lim = cfg_wdata;
        else cnt_lim = cfg_wdata;
      end
      if (in_valid && !in_stall) predict(in_data);
      if (out_valid && !out_stall) compare_result(out_data);
    end
    exp_depth = exp_results.size();
  end

endmodule

// ----- sim/sentence_boundary_splitter_test.sv -----
// Testbench top for the sentence boundary splitter: clock, reset, text
// stimulus, register writes and verdict. Uses sbs_pkg, the block and its checker.
`timescale 1ns / 1ps
module sentence_boundary_splitter_test;
  import sbs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LOWA   = 8'h61;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 25;
  localparam int N_PHASES     = 7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  in_item_t    in_data;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;
  logic        out_stall;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  int fail_count, exp_depth, sentences_seen, summaries_seen;
  int item_count;
  int quiet;
  bit no_idle;
  logic [7:0] txt[$];

  logic [15:0] phase_len [N_PHASES];
  logic [15:0] phase_cnt [N_PHASES];

  sentence_boundary_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sentence_boundary_splitter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .exp_depth      (exp_depth),
    .sentences_seen (sentences_seen),
    .summaries_seen (summaries_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("sentence_boundary_splitter_test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random hold-off before each transaction
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // starts and ends at a falling edge
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    int gap;
    gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data.opcode    <= op;
    in_data.text_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (op != OP_UNUSED) item_count++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++)
      send_item((i == s.len() - 1) ? OP_FINAL : OP_BYTE, s[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (exp_depth != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_limits(logic [15:0] len_v, logic [15:0] cnt_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LEN_LIMIT;
    cfg_wdata <= len_v;
    @(negedge clk);
    cfg_index <= CFG_COUNT_LIMIT;
    cfg_wdata <= cnt_v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return CH_TAB;
      1:       return CH_NL;
      2:       return CH_VT;
      3:       return CH_FF;
      4:       return CH_CR;
      default: return CH_SP;
    endcase
  endfunction

  function automatic logic [7:0] pick_mark();
    case ($urandom_range(0, 2))
      0:       return CH_DOT;
      1:       return CH_BANG;
      default: return CH_QUES;
    endcase
  endfunction

  task automatic append_sentence();
    int words;
    int len;
    if ($urandom_range(0, 3) == 0) txt.push_back(pick_space());
    txt.push_back(CH_UPA + 8'($urandom_range(0, 25)));
    words = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
    repeat (words) begin
      case ($urandom_range(0, 11))
        0: txt.push_back(CH_NL);
        1: begin
          // mark, space, lowercase: no boundary
          txt.push_back(pick_mark());
          txt.push_back(CH_SP);
        end
        2: txt.push_back(8'($urandom_range(0, 255)));
        3: txt.push_back(pick_mark());
        default: txt.push_back(CH_SP);
      endcase
      len = $urandom_range(1, 5);
      repeat (len) txt.push_back(CH_LOWA + 8'($urandom_range(0, 25)));
    end
    txt.push_back(pick_mark());
    case ($urandom_range(0, 4))
      0: ;
      1: txt.push_back(CH_NL);
      2: begin
        txt.push_back(CH_SP);
        txt.push_back(CH_SP);
      end
      default: txt.push_back(pick_space());
    endcase
  endtask

  task automatic build_text();
    int n;
    txt.delete();
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 12);
        repeat (n) txt.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        n = $urandom_range(0, 4);
        repeat (n) txt.push_back(pick_space());
      end
      default: begin
        n = $urandom_range(1, 5);
        repeat (n) append_sentence();
      end
    endcase
  endtask

  task automatic send_text();
    bit use_final;
    use_final = (txt.size() > 0) && ($urandom_range(0, 1) == 1);
    foreach (txt[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
      send_item((use_final && i == txt.size() - 1) ? OP_FINAL : OP_BYTE, txt[i]);
    end
    if (!use_final) send_item(OP_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int base;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_LEN_LIMIT;
    cfg_wdata  = '0;
    item_count = 0;
    no_idle    = 1'b0;
    phase_len  = '{16'd2, 16'd0, 16'd1, 16'hFFFF, 16'd12, 16'd20, LEN_LIMIT_RST};
    phase_cnt  = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd4, COUNT_LIMIT_RST};
    phase_len[5] = 16'($urandom_range(3, 40));
    phase_cnt[5] = 16'($urandom_range(1, 8));
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: breaks, blank lines, unused opcode, zero and all-ones bytes
    send_item(OP_UNUSED, 8'hFF);
    send_string("Hi. Ok!\n\n x?");
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CH_DOT);
    send_item(OP_BYTE, CH_TAB);
    send_item(OP_END, 8'hFF);
    send_item(OP_END, 8'h00);
    send_item(OP_FINAL, CH_BANG);
    send_string("x.y\n");
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      set_limits(phase_len[p], phase_cnt[p]);
      base = item_count;
      while (item_count - base < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 3) == 0);
        build_text();
        send_text();
      end
      settle();
    end

    $display("Sent %0d text transactions under %0d limit settings;",
             item_count, N_PHASES + 1);
    $display("checked %0d sentence and %0d summary results.", sentences_seen, summaries_seen);
    if (fail_count == 0 && exp_depth == 0) begin
      $display("sentence_boundary_splitter_test passed");
    end else begin
      $display("sentence_boundary_splitter_test failed");
    end
    $finish;
  end

endmodule
